### rtl/iee_pkg.sv
// Package for the infix expression evaluator.
// Holds character codes, state and operator encodings, and the request type
// of the shared multiply/divide unit. No dependencies.
package iee_pkg;

	// Widths fixed by the stream fields
	localparam int CHAR_W = 8;
	localparam int OUT_W  = 32;

	// Character codes that the parser recognizes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

	// What an accepted character asks the sequencer to do
	typedef enum logic [2:0] {
		K_NONE,
		K_ADD,
		K_SUB,
		K_MUL,
		K_DIV
	} kind_t;

	// Pending additive operator
	typedef enum logic {
		AOP_ADD,
		AOP_SUB
	} add_op_t;

	// Pending multiplicative operator
	typedef enum logic [1:0] {
		MOP_NONE,
		MOP_MUL,
		MOP_DIV
	} mul_op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NUM,
		ST_WAIT,
		ST_APPLY,
		ST_EMIT
	} state_t;

	// Operation of the shared unit
	typedef enum logic {
		MD_MUL,
		MD_DIV
	} md_op_t;

	// Request from the sequencer to the shared unit
	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_req_t;

endpackage

### rtl/iee_muldiv.sv
// Shared bit-serial unit: shift-add multiply and restoring unsigned divide.
// One operand bit per cycle. Depends on iee_pkg.
module iee_muldiv #(
	parameter int W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  iee_pkg::md_req_t   req,
	input  logic [W-1:0]       opa,
	input  logic [W-1:0]       opb,
	output logic               done,
	output logic [W-1:0]       result
);
	import iee_pkg::*;

	localparam int CW = $clog2(W);

	logic          run_q;
	logic          done_q;
	md_op_t        op_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;

	logic [W:0]    shifted;
	logic          fits;

	// Divide step: bring in the next dividend bit and try a subtract.
	assign shifted = {acc_q, a_q[W-1]};
	assign fits    = shifted >= {1'b0, b_q};

	// Control: step the bit counter while running, then pulse done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: accumulator/remainder, multiplicand/quotient, multiplier/divisor.
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			acc_q <= '0;
			a_q   <= opa;
			b_q   <= opb;
		end else if (run_q) begin
			unique case (op_q)
				MD_MUL: begin
					acc_q <= acc_q + (b_q[0] ? a_q : '0);
					a_q   <= {a_q[W-2:0], 1'b0};
					b_q   <= {1'b0, b_q[W-1:1]};
				end
				MD_DIV: begin
					acc_q <= fits ? W'(shifted - {1'b0, b_q}) : shifted[W-1:0];
					a_q   <= {a_q[W-2:0], fits};
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = (op_q == MD_DIV) ? a_q : acc_q;

endmodule

### rtl/infix_expression_evaluator.sv
// Top level of the infix expression evaluator: character parser, sequencer,
// running state and output register. Depends on iee_pkg and iee_muldiv.
//
//   Channel  Dir  Word                         Framing
//   s_axis   in   tdata = char_code (8 bits)   tlast = last_char
//   m_axis   out  tdata = value (32 bits)      tuser = error
//
// A digit, space or other character is taken in ST_IDLE. An operator closes the
// pending number through ST_NUM, ST_WAIT when the bit-serial unit multiplies or
// divides by a nonzero number, and ST_APPLY. The last character adds such a close,
// a second one if it is an operator, and then ST_EMIT loads the output register.
// Reset clears the sequencer state and the output valid; no clearing pass is needed.
// A result waits in the output register, and the next one stalls until it is taken.
module infix_expression_evaluator #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [iee_pkg::CHAR_W-1:0]  s_axis_tdata,  // [7:0] char_code
	input  logic                        s_axis_tlast,  // last_char
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [iee_pkg::OUT_W-1:0]   m_axis_tdata,  // [31:0] value
	output logic                        m_axis_tuser   // [0] error
);
	import iee_pkg::*;

	localparam int W = DATA_WIDTH;

	state_t        state_q, state_d;
	logic [W-1:0]  sum_q, sum_d;
	logic [W-1:0]  term_q, term_d;
	logic [W-1:0]  num_q, num_d;
	add_op_t       add_op_q, add_op_d;
	mul_op_t       mul_op_q, mul_op_d;
	logic          err_q, err_d;
	kind_t         kind_q, kind_d;
	logic          last_q, last_d;
	logic          fin_q, fin_d;
	logic          neg_q, neg_d;

	logic          out_valid_q;
	logic [OUT_W-1:0] out_value_q;
	logic          out_error_q;
	logic          load_out;

	md_req_t       md_req;
	logic [W-1:0]  md_a;
	logic [W-1:0]  md_b;
	logic          md_done;
	logic [W-1:0]  md_result;

	kind_t         char_kind;
	logic          is_digit;
	logic          is_space;
	logic [3:0]    digit;
	logic [W-1:0]  term_mag;
	logic [W-1:0]  num_mag;

	// Character classification.
	assign is_digit = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
	assign is_space = (s_axis_tdata == CH_SPACE);
	assign digit    = 4'(s_axis_tdata - CH_ZERO);

	always_comb begin
		priority if (s_axis_tdata == CH_PLUS)  char_kind = K_ADD;
		else if (s_axis_tdata == CH_MINUS)     char_kind = K_SUB;
		else if (s_axis_tdata == CH_STAR)      char_kind = K_MUL;
		else if (s_axis_tdata == CH_SLASH)     char_kind = K_DIV;
		else                                   char_kind = K_NONE;
	end

	// Magnitudes for the signed divide.
	assign term_mag = term_q[W-1] ? W'(-term_q) : term_q;
	assign num_mag  = num_q[W-1] ? W'(-num_q) : num_q;

	// Shared multiply/divide unit.
	iee_muldiv #(
		.W(W)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.opa    (md_a),
		.opb    (md_b),
		.done   (md_done),
		.result (md_result)
	);

	// Sequencer: next state and datapath updates.
	always_comb begin
		state_d  = state_q;
		sum_d    = sum_q;
		term_d   = term_q;
		num_d    = num_q;
		add_op_d = add_op_q;
		mul_op_d = mul_op_q;
		err_d    = err_q;
		kind_d   = kind_q;
		last_d   = last_q;
		fin_d    = fin_q;
		neg_d    = neg_q;
		md_req   = '{start: 1'b0, op: MD_MUL};
		md_a     = term_q;
		md_b     = num_q;
		load_out = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					last_d = s_axis_tlast;
					if (is_digit) begin
						num_d = (num_q << 3) + (num_q << 1) + W'(digit);
					end else if (!is_space && char_kind == K_NONE) begin
						err_d = 1'b1;
					end
					if (char_kind != K_NONE) begin
						kind_d  = char_kind;
						fin_d   = 1'b0;
						state_d = ST_NUM;
					end else if (s_axis_tlast) begin
						kind_d  = K_ADD;
						fin_d   = 1'b1;
						state_d = ST_NUM;
					end
				end
			end

			// Close the number under the pending multiplicative operator.
			ST_NUM: begin
				unique case (mul_op_q)
					MOP_MUL: begin
						md_req  = '{start: 1'b1, op: MD_MUL};
						neg_d   = 1'b0;
						state_d = ST_WAIT;
					end
					MOP_DIV: begin
						if (num_q == '0) begin
							err_d   = 1'b1;
							term_d  = '0;
							num_d   = '0;
							state_d = ST_APPLY;
						end else begin
							md_req  = '{start: 1'b1, op: MD_DIV};
							md_a    = term_mag;
							md_b    = num_mag;
							neg_d   = term_q[W-1] ^ num_q[W-1];
							state_d = ST_WAIT;
						end
					end
					default: begin
						term_d  = num_q;
						num_d   = '0;
						state_d = ST_APPLY;
					end
				endcase
			end

			ST_WAIT: begin
				if (md_done) begin
					term_d  = neg_q ? W'(-md_result) : md_result;
					num_d   = '0;
					state_d = ST_APPLY;
				end
			end

			// Apply the operator itself, then decide whether to close the expression.
			ST_APPLY: begin
				unique case (kind_q)
					K_MUL: mul_op_d = MOP_MUL;
					K_DIV: mul_op_d = MOP_DIV;
					K_ADD, K_SUB: begin
						sum_d    = (add_op_q == AOP_SUB) ? sum_q - term_q : sum_q + term_q;
						term_d   = '0;
						mul_op_d = MOP_NONE;
						add_op_d = (kind_q == K_SUB) ? AOP_SUB : AOP_ADD;
					end
					default: begin
						mul_op_d = mul_op_q;
					end
				endcase
				if (fin_q) begin
					state_d = ST_EMIT;
				end else if (last_q) begin
					kind_d  = K_ADD;
					fin_d   = 1'b1;
					state_d = ST_NUM;
				end else begin
					state_d = ST_IDLE;
				end
			end

			// Hand the result to the output register and clear for the next expression.
			ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					sum_d    = '0;
					term_d   = '0;
					num_d    = '0;
					add_op_d = AOP_ADD;
					mul_op_d = MOP_NONE;
					err_d    = 1'b0;
					last_d   = 1'b0;
					fin_d    = 1'b0;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sum_q    <= '0;
			term_q   <= '0;
			num_q    <= '0;
			add_op_q <= AOP_ADD;
			mul_op_q <= MOP_NONE;
			err_q    <= 1'b0;
			kind_q   <= K_NONE;
			last_q   <= 1'b0;
			fin_q    <= 1'b0;
			neg_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			sum_q    <= sum_d;
			term_q   <= term_d;
			num_q    <= num_d;
			add_op_q <= add_op_d;
			mul_op_q <= mul_op_d;
			err_q    <= err_d;
			kind_q   <= kind_d;
			last_q   <= last_d;
			fin_q    <= fin_d;
			neg_q    <= neg_d;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload; the sum is sign extended or wrapped to the word.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= err_q ? '0 : OUT_W'(signed'(sum_q));
			out_error_q <= err_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = out_error_q;

endmodule

### rtl/iee_checker.sv
// Port-level checks for the infix expression evaluator, and the bind that
// attaches them to the top level. Depends on iee_pkg.
module iee_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [iee_pkg::CHAR_W-1:0]  s_axis_tdata,
	input  logic                        s_axis_tlast,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [iee_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic                        m_axis_tuser
);
	import iee_pkg::*;

	logic in_word;
	logic is_op;
	logic is_digit;

	assign in_word  = s_axis_tvalid && s_axis_tready;
	assign is_op    = (s_axis_tdata == CH_PLUS) || (s_axis_tdata == CH_MINUS) ||
	                  (s_axis_tdata == CH_STAR) || (s_axis_tdata == CH_SLASH);
	assign is_digit = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// An errored expression always reports a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("error result with nonzero value");

	// Closing an expression keeps the input side busy.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_word && s_axis_tlast |=> !s_axis_tready)
		else $error("input ready right after last character");

	// An operator word starts work on the sequencer.
	a_op_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_word && is_op |=> !s_axis_tready)
		else $error("input ready right after an operator");

	// A plain digit inside an expression is absorbed in ST_IDLE, so the input is ready again in the next cycle.
	a_digit_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_word && is_digit && !s_axis_tlast |=> s_axis_tready)
		else $error("digit did not complete in one cycle");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
